@@ design/hop_distance_closure_unit_defines.svh @@
// Assertion macros used by the RTL.
`ifndef HOP_DISTANCE_CLOSURE_UNIT_DEFINES_SVH
`define HOP_DISTANCE_CLOSURE_UNIT_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define HDC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent in the cycle after the antecedent.
`define HDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/hdc_pkg.sv @@
package hdc_pkg;
	localparam int MAX_NODES = 64;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int DIST_W    = 7;
	localparam int ADDR_W    = 2 * NODE_W;
	localparam int FUNC_W    = 2;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [FUNC_W-1:0] func_t;

	localparam func_t FUNC_CLEAR = 2'd0;
	localparam func_t FUNC_ARC   = 2'd1;
	localparam func_t FUNC_QUERY = 2'd2;

	// Node count clamped to the range 1 to MAX_NODES.
	function automatic dist_t eff_nodes(input dist_t n);
		dist_t r;
		r = n;
		if (n == '0) begin
			r = dist_t'(1);
		end else if (n > dist_t'(MAX_NODES)) begin
			r = dist_t'(MAX_NODES);
		end
		return r;
	endfunction
endpackage

@@ design/hop_distance_closure_unit.sv @@
// Arc item: written as it is accepted. Clear item or num_nodes write: a fill pass over the whole matrix, input stalled.
// Query on a clean matrix: accepted, then read in ST_QRD and registered to the output in ST_QOUT once it is free.
// Query on a stale matrix: closure first, ST_RP and ST_RPC per pivot and row plus an ST_COL pass over the N
// columns of each row that is not skipped, paced by the two-read, one-write memory port.
// Asynchronous reset clears control, sets num_nodes to 64 and starts a fill pass.
`include "hop_distance_closure_unit_defines.svh"
module hop_distance_closure_unit
	import hdc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [6:0]   cfg_wr_data,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [1:0]   func,
	input  logic [5:0]   from_node,
	input  logic [5:0]   to_node,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [6:0]   distance
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FILL  = 3'd1;
	localparam logic [2:0] ST_RP    = 3'd2;
	localparam logic [2:0] ST_RPC   = 3'd3;
	localparam logic [2:0] ST_COL   = 3'd4;
	localparam logic [2:0] ST_QWAIT = 3'd5;
	localparam logic [2:0] ST_QRD   = 3'd6;
	localparam logic [2:0] ST_QOUT  = 3'd7;

	logic [2:0]  state_q;
	dist_t       num_nodes_q;
	dist_t       n_eff;
	logic        stale_q;
	addr_t       fill_cnt_q;
	node_t       p_q, r_q, c_q;
	dist_t       rp_q;
	node_t       q_from_q, q_to_q;
	logic        q_oor_q;
	logic        out_valid_q;
	dist_t       distance_q;

	logic        v_s1;
	addr_t       waddr_s1;

	dist_t       mem [0:(1 << ADDR_W)-1];
	dist_t       rd_a_q, rd_b_q;
	addr_t       addr_a, addr_b;
	logic        mem_we;
	addr_t       mem_waddr;
	dist_t       mem_wdata;

	logic [DIST_W:0] via;
	logic        cl_we;
	logic        in_xfer;
	logic        in_range;
	logic        last_r, last_p, last_c;
	logic        out_free;

	assign n_eff     = eff_nodes(num_nodes_q);
	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign in_range  = ({1'b0, from_node} < n_eff) && ({1'b0, to_node} < n_eff);
	assign last_r    = ({1'b0, r_q} == n_eff - dist_t'(1));
	assign last_p    = ({1'b0, p_q} == n_eff - dist_t'(1));
	assign last_c    = ({1'b0, c_q} == n_eff - dist_t'(1));
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign distance  = distance_q;

	assign via   = {1'b0, rp_q} + {1'b0, rd_b_q};
	assign cl_we = v_s1 && (via < {1'b0, rd_a_q});

	always_comb begin
		case (state_q)
			ST_RP:   addr_a = {r_q, p_q};
			ST_COL:  addr_a = {r_q, c_q};
			default: addr_a = {q_from_q, q_to_q};
		endcase
		addr_b = {p_q, c_q};
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = waddr_s1;
		mem_wdata = via[DIST_W-1:0];
		if (state_q == ST_FILL) begin
			mem_we    = 1'b1;
			mem_waddr = fill_cnt_q;
			mem_wdata = n_eff;
		end else if (cl_we) begin
			mem_we = 1'b1;
		end else if (in_xfer && func == FUNC_ARC && in_range) begin
			mem_we    = 1'b1;
			mem_waddr = {from_node, to_node};
			mem_wdata = dist_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= {r_q, c_q};
		if (state_q == ST_RPC) begin
			rp_q <= rd_a_q;
		end
		if (in_xfer && func == FUNC_QUERY) begin
			q_from_q <= from_node;
			q_to_q   <= to_node;
			q_oor_q  <= !in_range;
		end
		if (state_q == ST_QOUT && out_free) begin
			distance_q <= q_oor_q ? n_eff : rd_a_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			num_nodes_q <= dist_t'(MAX_NODES);
			stale_q     <= 1'b0;
			fill_cnt_q  <= '0;
			p_q         <= '0;
			r_q         <= '0;
			c_q         <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_COL);
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				num_nodes_q <= cfg_wr_data;
				state_q     <= ST_FILL;
				fill_cnt_q  <= '0;
				stale_q     <= 1'b0;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (in_xfer) begin
							case (func)
								FUNC_CLEAR: begin
									state_q    <= ST_FILL;
									fill_cnt_q <= '0;
									stale_q    <= 1'b0;
								end
								FUNC_ARC: begin
									if (in_range) begin
										stale_q <= 1'b1;
									end
								end
								FUNC_QUERY: begin
									p_q <= '0;
									r_q <= '0;
									state_q <= stale_q ? ST_RP : ST_QRD;
								end
								default: begin
								end
							endcase
						end
					end
					ST_FILL: begin
						fill_cnt_q <= fill_cnt_q + addr_t'(1);
						if (fill_cnt_q == '1) begin
							state_q <= ST_IDLE;
						end
					end
					ST_RP: begin
						state_q <= ST_RPC;
					end
					ST_RPC, ST_COL: begin
						c_q <= c_q + node_t'(1);
						if (state_q == ST_RPC && rd_a_q < n_eff) begin
							c_q     <= '0;
							state_q <= ST_COL;
						end else if (state_q == ST_RPC || last_c) begin
							// The row is finished or cannot improve: move on.
							if (last_r && last_p) begin
								state_q <= ST_QWAIT;
							end else if (last_r) begin
								r_q     <= '0;
								p_q     <= p_q + node_t'(1);
								state_q <= ST_RP;
							end else begin
								r_q     <= r_q + node_t'(1);
								state_q <= ST_RP;
							end
						end
					end
					ST_QWAIT: begin
						stale_q <= 1'b0;
						state_q <= ST_QRD;
					end
					ST_QRD: begin
						state_q <= ST_QOUT;
					end
					ST_QOUT: begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	`HDC_ASSERT_SAME(a_pivot_range,
		(state_q == ST_RP || state_q == ST_RPC || state_q == ST_COL),
		({1'b0, p_q} < n_eff && {1'b0, r_q} < n_eff), "closure index out of range")
	`HDC_ASSERT_SAME(a_relax_min, cl_we,
		(via[DIST_W-1:0] >= dist_t'(2) && via[DIST_W] == 1'b0),
		"closure wrote an impossible distance")
	`HDC_ASSERT_SAME(a_fill_clean, (state_q == ST_FILL), (!stale_q), "matrix stale during fill")
	`HDC_ASSERT_NEXT(a_query_done, (state_q == ST_QWAIT && !cfg_wr_en),
		(!stale_q && state_q == ST_QRD), "closure did not finish cleanly")
endmodule
